/* sv/uart_bit_receiver_fifo_defines.svh */
`ifndef UART_BIT_RECEIVER_FIFO_DEFINES_SVH
`define UART_BIT_RECEIVER_FIFO_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define URBF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define URBF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/urbf_pkg.sv */
package urbf_pkg;

	// receive byte store
	localparam int FIFO_DEPTH = 64;
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W = 6;

	// command queue between receiver and byte store
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// register port
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_DATA_BITS = 2'd0;
	localparam logic [1:0] REG_STOP_BITS = 2'd1;
	localparam logic [1:0] REG_BIT_TIME = 2'd2;
	localparam logic [1:0] REG_FIRST_DELAY = 2'd3;

	localparam logic [3:0] DATA_BITS_RST = 4'd8;
	localparam logic [1:0] STOP_BITS_RST = 2'd1;
	localparam logic [15:0] BIT_TIME_RST = 16'd8333;
	localparam logic [15:0] FIRST_DELAY_RST = 16'd11110;

	typedef struct packed {
		logic [3:0] data_bits;
		logic [1:0] stop_bits;
		logic [15:0] bit_time;
		logic [15:0] first_sample_delay;
	} cfg_t;

	// one tick's work for the byte store
	typedef struct packed {
		logic pop;
		logic flush;
		logic clr;
		logic push;
		logic [7:0] push_byte;
	} cmd_t;

endpackage

/* sv/urbf_in_if.sv */
interface urbf_in_if;
	logic valid;
	logic ready;
	logic line_level;
	logic pop_request;
	logic flush_request;
	logic clear_overflow;

	modport source (
		output valid, line_level, pop_request, flush_request, clear_overflow,
		input ready
	);
	modport sink (
		input valid, line_level, pop_request, flush_request, clear_overflow,
		output ready
	);
endinterface

/* sv/urbf_out_if.sv */
interface urbf_out_if;
	logic valid;
	logic ready;
	logic [7:0] popped_byte;
	logic popped_valid;
	logic [5:0] fill_level;
	logic overflow_seen;

	modport source (
		output valid, popped_byte, popped_valid, fill_level, overflow_seen,
		input ready
	);
	modport sink (
		input valid, popped_byte, popped_valid, fill_level, overflow_seen,
		output ready
	);
endinterface

/* sv/urbf_front.sv */
module urbf_front (
	input logic clk,
	input logic arst_n,
	input urbf_pkg::cfg_t cfg,
	urbf_in_if.sink items,
	output logic cmd_valid,
	output urbf_pkg::cmd_t cmd,
	input logic cmd_ready
);
	import urbf_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;
	localparam logic [1:0] STOP_TWO = 2'd2;

	function automatic logic [15:0] load_value(input logic [15:0] v);
		return (v == 16'd0) ? 16'd0 : v - 16'd1;
	endfunction

	logic [1:0] phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] nbits;
	logic [3:0] bits_inc;
	logic [7:0] shift_smp;
	logic push;
	logic accept;

	assign accept = items.valid && cmd_ready;
	assign items.ready = cmd_ready;
	assign cmd_valid = items.valid;

	always_comb begin
		if (cfg.data_bits < 4'd5) begin
			nbits = 4'd5;
		end else if (cfg.data_bits > 4'd8) begin
			nbits = 4'd8;
		end else begin
			nbits = cfg.data_bits;
		end
	end

	assign bits_inc = bits_q + 4'd1;
	// new bit enters at the top of the character, lsb first
	assign shift_smp = (shift_q >> 1) | (8'(items.line_level) << (nbits - 4'd1));

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		bits_d = bits_q;
		shift_d = shift_q;
		push = 1'b0;
		unique case (phase_q)
			PH_DATA: begin
				if (tick_q != 16'd0) begin
					tick_d = tick_q - 16'd1;
				end else begin
					shift_d = shift_smp;
					bits_d = bits_inc;
					tick_d = load_value(cfg.bit_time);
					if (bits_inc >= nbits) begin
						push = 1'b1;
						phase_d = PH_STOP;
						bits_d = 4'd0;
					end
				end
			end
			PH_STOP: begin
				if (tick_q != 16'd0) begin
					tick_d = tick_q - 16'd1;
				end else begin
					bits_d = bits_inc;
					if (cfg.stop_bits == STOP_TWO && bits_inc < 4'd2) begin
						tick_d = load_value(cfg.bit_time);
					end else begin
						phase_d = PH_IDLE;
						bits_d = 4'd0;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (!items.line_level) begin
					phase_d = PH_DATA;
					tick_d = load_value(cfg.first_sample_delay);
					bits_d = 4'd0;
					shift_d = 8'd0;
				end
			end
		endcase
	end

	always_comb begin
		cmd.pop = items.pop_request;
		cmd.flush = items.flush_request;
		cmd.clr = items.clear_overflow;
		cmd.push = push;
		cmd.push_byte = shift_smp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= 16'd0;
			bits_q <= 4'd0;
			shift_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			bits_q <= bits_d;
			shift_q <= shift_d;
		end
	end

endmodule

/* sv/urbf_queue.sv */
module urbf_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input urbf_pkg::cmd_t in_cmd,
	output logic in_ready,
	output logic out_valid,
	output urbf_pkg::cmd_t out_cmd,
	input logic out_ready
);
	import urbf_pkg::*;

	cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	function automatic logic [QPTR_W-1:0] qinc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign in_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd = entry_q[rd_q];
	assign do_push = in_valid && in_ready;
	assign do_pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= qinc(wr_q);
			end
			if (do_pop) begin
				rd_q <= qinc(rd_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* sv/urbf_back.sv */
module urbf_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input urbf_pkg::cmd_t cmd,
	output logic cmd_ready,
	urbf_out_if.source results
);
	import urbf_pkg::*;

	function automatic logic [PTR_W-1:0] pinc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	logic [7:0] store_q [FIFO_DEPTH];
	logic [7:0] rdata_q;
	logic [PTR_W-1:0] wp_q, rp_q;
	logic ovf_q;
	logic res_valid_q;
	logic pop_ok_s1;
	logic [FILL_W-1:0] fill_s1;
	logic ovf_s1;

	logic take;
	logic pop_ok;
	logic [PTR_W:0] diff;
	logic [PTR_W-1:0] fill;
	logic [PTR_W-1:0] wp1, rp1, wp_next, wp_d;
	logic ovf_d;
	logic wr_en;

	assign cmd_ready = !res_valid_q || results.ready;
	assign take = cmd_valid && cmd_ready;

	always_comb begin
		diff = (PTR_W + 1)'(wp_q) - (PTR_W + 1)'(rp_q);
		if (wp_q < rp_q) begin
			diff = diff + (PTR_W + 1)'(FIFO_DEPTH);
		end
		fill = diff[PTR_W-1:0];
	end

	// order within a tick: pop, flush, clear, then the receiver's byte
	always_comb begin
		pop_ok = cmd.pop && (wp_q != rp_q);
		rp1 = pop_ok ? pinc(rp_q) : rp_q;
		wp1 = wp_q;
		if (cmd.flush) begin
			rp1 = '0;
			wp1 = '0;
		end
		ovf_d = cmd.clr ? 1'b0 : ovf_q;
		wp_next = pinc(wp1);
		wr_en = 1'b0;
		wp_d = wp1;
		if (cmd.push) begin
			if (wp_next != rp1) begin
				wr_en = 1'b1;
				wp_d = wp_next;
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	// read before write: a pop sees the old entry
	always_ff @(posedge clk) begin
		if (take) begin
			rdata_q <= store_q[rp_q];
			if (wr_en) begin
				store_q[wp1] <= cmd.push_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pop_ok_s1 <= pop_ok;
			fill_s1 <= FILL_W'(fill);
			ovf_s1 <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			ovf_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				wp_q <= wp_d;
				rp_q <= rp1;
				ovf_q <= ovf_d;
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = res_valid_q;
	assign results.popped_byte = pop_ok_s1 ? rdata_q : 8'd0;
	assign results.popped_valid = pop_ok_s1;
	assign results.fill_level = fill_s1;
	assign results.overflow_seen = ovf_s1;

endmodule

/* sv/uart_bit_receiver_fifo.sv */
// UART receiver with a receive byte FIFO. Each transaction on items is one clock tick of the
// sampled receive line together with pop, flush and overflow-clear requests; each one yields
// exactly one transaction on results. One transaction is taken every cycle while the queue
// has room: the receiver updates its bit timer in the cycle the tick is taken, and the byte
// store handles one queued tick per cycle while results are taken, through its single
// registered read port. A four-entry queue between receiver and byte store lets the input
// keep flowing while results stall. Registers (APB, byte addresses): 0x0 data_bits, 0x4
// stop_bits, 0x8 bit_time, 0xC first_sample_delay.
`include "uart_bit_receiver_fifo_defines.svh"

module uart_bit_receiver_fifo (
	input logic clk,
	input logic arst_n,
	urbf_in_if.sink items,
	urbf_out_if.source results,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [urbf_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import urbf_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;
	logic [1:0] reg_sel;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_ready;
	logic q_valid;
	cmd_t q_cmd;
	logic q_ready;

	assign pready = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bits <= DATA_BITS_RST;
			cfg_q.stop_bits <= STOP_BITS_RST;
			cfg_q.bit_time <= BIT_TIME_RST;
			cfg_q.first_sample_delay <= FIRST_DELAY_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_DATA_BITS: cfg_q.data_bits <= pwdata[3:0];
				REG_STOP_BITS: cfg_q.stop_bits <= pwdata[1:0];
				REG_BIT_TIME: cfg_q.bit_time <= pwdata[15:0];
				REG_FIRST_DELAY: cfg_q.first_sample_delay <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DATA_BITS: prdata = 32'(cfg_q.data_bits);
			REG_STOP_BITS: prdata = 32'(cfg_q.stop_bits);
			REG_BIT_TIME: prdata = 32'(cfg_q.bit_time);
			REG_FIRST_DELAY: prdata = 32'(cfg_q.first_sample_delay);
			default: prdata = 32'd0;
		endcase
	end

	urbf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.items(items),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready)
	);

	urbf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd_valid),
		.in_cmd(cmd),
		.in_ready(cmd_ready),
		.out_valid(q_valid),
		.out_cmd(q_cmd),
		.out_ready(q_ready)
	);

	urbf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_valid),
		.cmd(q_cmd),
		.cmd_ready(q_ready),
		.results(results)
	);

	`URBF_ASSERT_IMP(a_pop_needs_data, results.valid && results.popped_valid, results.fill_level != 6'd0, "pop reported on an empty fifo")
	`URBF_ASSERT_IMP(a_empty_pop_zero, results.valid && !results.popped_valid, results.popped_byte == 8'd0, "failed pop carries a nonzero byte")
	`URBF_ASSERT_IMP(a_full_queue_valid, !cmd_ready, q_valid, "queue full but offers nothing")
	`URBF_ASSERT_NXT(a_push_lands, cmd_valid && cmd_ready, q_valid, "queued transaction vanished")

endmodule

/* verif/uart_bit_receiver_fifo_tb.sv */
`timescale 1ns / 100ps

module uart_bit_receiver_fifo_tb;
	import urbf_pkg::*;

	typedef struct packed {
		logic line_level;
		logic pop_request;
		logic flush_request;
		logic clear_overflow;
	} tick_t;

	typedef struct packed {
		logic [7:0] popped_byte;
		logic popped_valid;
		logic [5:0] fill_level;
		logic overflow_seen;
	} rx_result_t;

	typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_STOP} rx_phase_e;

	localparam tick_t NO_REQ = '{line_level: 1'b0, pop_request: 1'b0,
		flush_request: 1'b0, clear_overflow: 1'b0};
	localparam tick_t IDLE_LINE = '{line_level: 1'b1, pop_request: 1'b0,
		flush_request: 1'b0, clear_overflow: 1'b0};
	localparam tick_t POP_REQ = '{line_level: 1'b0, pop_request: 1'b1,
		flush_request: 1'b0, clear_overflow: 1'b0};
	localparam tick_t FLUSH_REQ = '{line_level: 1'b0, pop_request: 1'b0,
		flush_request: 1'b1, clear_overflow: 1'b0};
	localparam tick_t CLEAR_REQ = '{line_level: 1'b0, pop_request: 1'b0,
		flush_request: 1'b0, clear_overflow: 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic drv_valid = 1'b0;
	tick_t drv_tick = IDLE_LINE;
	logic rdy = 1'b0;
	logic no_stall = 1'b0;

	urbf_in_if in_bus ();
	urbf_out_if out_bus ();

	assign in_bus.valid = drv_valid;
	assign in_bus.line_level = drv_tick.line_level;
	assign in_bus.pop_request = drv_tick.pop_request;
	assign in_bus.flush_request = drv_tick.flush_request;
	assign in_bus.clear_overflow = drv_tick.clear_overflow;
	assign out_bus.ready = rdy;

	uart_bit_receiver_fifo uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(in_bus),
		.results(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// shadow registers, shared by the stimulus and the receiver model
	logic [3:0] cfg_data_bits = DATA_BITS_RST;
	logic [1:0] cfg_stop_bits = STOP_BITS_RST;
	logic [15:0] cfg_bit_time = BIT_TIME_RST;
	logic [15:0] cfg_first_delay = FIRST_DELAY_RST;

	// receiver and byte store model
	rx_phase_e rx_phase = RX_IDLE;
	logic [15:0] rx_count = '0;
	logic [3:0] rx_bits = '0;
	logic [7:0] rx_shift = '0;
	logic [7:0] char_store [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr = '0;
	logic [PTR_W-1:0] rd_ptr = '0;
	logic overflow_flag = 1'b0;

	tick_t pending_ticks[$];
	rx_result_t expected_results[$];

	int mismatches = 0;
	int ticks_queued = 0;
	int ticks_taken = 0;
	int results_seen = 0;
	int frames_sent = 0;
	int settings_used = 0;
	int bytes_popped = 0;
	int overflow_results = 0;

	function automatic int char_bits();
		if (cfg_data_bits < 5) return 5;
		if (cfg_data_bits > 8) return 8;
		return cfg_data_bits;
	endfunction

	function automatic int stop_count();
		return (cfg_stop_bits == 2'd2) ? 2 : 1;
	endfunction

	function automatic int eff_bit_time();
		return (cfg_bit_time == 0) ? 1 : cfg_bit_time;
	endfunction

	function automatic int eff_first_delay();
		return (cfg_first_delay == 0) ? 1 : cfg_first_delay;
	endfunction

	function automatic logic [15:0] reload(input logic [15:0] v);
		return (v == 0) ? 16'd0 : v - 16'd1;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("ERROR at %0t ns, result %0d: %s", $realtime, results_seen, what);
		mismatches++;
	endtask

	task automatic store_char(input logic [7:0] ch);
		logic [PTR_W-1:0] nxt;
		nxt = wr_ptr + 1'b1;
		if (nxt != rd_ptr) begin
			char_store[wr_ptr] = ch;
			wr_ptr = nxt;
		end else begin
			overflow_flag = 1'b1;
		end
	endtask

	// one accepted tick: pop, flush, clear, then the receiver step
	task automatic predict_tick(input tick_t tk);
		rx_result_t r;
		int n;
		r = '0;
		r.fill_level = 6'(wr_ptr - rd_ptr);
		r.overflow_seen = overflow_flag;
		if (tk.pop_request && wr_ptr != rd_ptr) begin
			r.popped_byte = char_store[rd_ptr];
			r.popped_valid = 1'b1;
			rd_ptr = rd_ptr + 1'b1;
		end
		if (tk.flush_request) begin
			wr_ptr = '0;
			rd_ptr = '0;
		end
		if (tk.clear_overflow)
			overflow_flag = 1'b0;
		case (rx_phase)
			RX_DATA: begin
				if (rx_count != 0) begin
					rx_count = rx_count - 1'b1;
				end else begin
					n = char_bits();
					rx_shift = (rx_shift >> 1) | (8'(tk.line_level) << (n - 1));
					rx_bits = rx_bits + 1'b1;
					rx_count = reload(cfg_bit_time);
					if (rx_bits >= n) begin
						store_char(rx_shift);
						rx_phase = RX_STOP;
						rx_bits = '0;
					end
				end
			end
			RX_STOP: begin
				if (rx_count != 0) begin
					rx_count = rx_count - 1'b1;
				end else begin
					rx_bits = rx_bits + 1'b1;
					if (cfg_stop_bits == 2'd2 && rx_bits < 2) begin
						rx_count = reload(cfg_bit_time);
					end else begin
						rx_phase = RX_IDLE;
						rx_bits = '0;
					end
				end
			end
			default: begin
				rx_phase = RX_IDLE;
				if (!tk.line_level) begin
					rx_phase = RX_DATA;
					rx_count = reload(cfg_first_delay);
					rx_bits = '0;
					rx_shift = '0;
				end
			end
		endcase
		expected_results.push_back(r);
	endtask

	task automatic check_result();
		rx_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with no tick waiting");
			return;
		end
		want = expected_results.pop_front();
		if (out_bus.popped_byte !== want.popped_byte)
			report_mismatch($sformatf("popped_byte %0h, expected %0h",
				out_bus.popped_byte, want.popped_byte));
		if (out_bus.popped_valid !== want.popped_valid)
			report_mismatch($sformatf("popped_valid %0b, expected %0b",
				out_bus.popped_valid, want.popped_valid));
		if (out_bus.fill_level !== want.fill_level)
			report_mismatch($sformatf("fill_level %0d, expected %0d",
				out_bus.fill_level, want.fill_level));
		if (out_bus.overflow_seen !== want.overflow_seen)
			report_mismatch($sformatf("overflow_seen %0b, expected %0b",
				out_bus.overflow_seen, want.overflow_seen));
		results_seen++;
		if (want.popped_valid)
			bytes_popped++;
		if (want.overflow_seen)
			overflow_results++;
	endtask

	// driver: one tick per transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_tick <= IDLE_LINE;
		end else begin
			if (drv_valid && in_bus.ready) begin
				predict_tick(drv_tick);
				ticks_taken++;
			end
			if (!drv_valid || in_bus.ready) begin
				if (pending_ticks.size() != 0 && (no_stall || $urandom_range(0, 99) >= 8)) begin
					drv_valid <= 1'b1;
					drv_tick <= pending_ticks.pop_front();
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy <= 1'b0;
		end else begin
			if (out_bus.valid && rdy)
				check_result();
			rdy <= no_stall || ($urandom_range(0, 99) >= 8);
		end
	end

	function automatic tick_t random_requests(input logic lvl, input int pop_pct,
		input int flush_pct, input int clr_pct);
		tick_t tk;
		tk.line_level = lvl;
		tk.pop_request = $urandom_range(0, 99) < pop_pct;
		tk.flush_request = $urandom_range(0, 99) < flush_pct;
		tk.clear_overflow = $urandom_range(0, 99) < clr_pct;
		return tk;
	endfunction

	task automatic queue_tick(input tick_t tk);
		pending_ticks.push_back(tk);
		ticks_queued++;
	endtask

	// wait until every queued tick has had its result checked
	task automatic drain();
		do @(posedge clk);
		while (results_seen != ticks_queued);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] held;
		apb_access(idx, 1'b1, val);
		case (idx)
			REG_DATA_BITS: begin
				cfg_data_bits = val[3:0];
				held = 32'(val[3:0]);
			end
			REG_STOP_BITS: begin
				cfg_stop_bits = val[1:0];
				held = 32'(val[1:0]);
			end
			REG_BIT_TIME: begin
				cfg_bit_time = val[15:0];
				held = 32'(val[15:0]);
			end
			default: begin
				cfg_first_delay = val[15:0];
				held = 32'(val[15:0]);
			end
		endcase
		// read back; prdata is sampled at the access edge
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== held)
			report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, held));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int dbits, input int sbits, input int btime, input int fdelay);
		write_reg(REG_DATA_BITS, 32'(dbits));
		write_reg(REG_STOP_BITS, 32'(sbits));
		write_reg(REG_BIT_TIME, 32'(btime));
		write_reg(REG_FIRST_DELAY, 32'(fdelay));
		settings_used++;
	endtask

	// start bit, data bits LSB first, stop time; non-sample ticks get some glitches
	task automatic send_frame(input logic [7:0] value, input int pop_pct, input int flush_pct,
		input int clr_pct, input tick_t on_store);
		int bt, fsd, last_sample, span;
		logic lvl;
		tick_t tk;
		bt = eff_bit_time();
		fsd = eff_first_delay();
		last_sample = fsd + (char_bits() - 1) * bt;
		span = last_sample + stop_count() * bt;
		for (int t = 0; t <= span; t++) begin
			if (t == 0)
				lvl = 1'b0;
			else if (t >= fsd && t <= last_sample && (t - fsd) % bt == 0)
				lvl = value[(t - fsd) / bt];
			else if ($urandom_range(0, 3) == 0)
				lvl = 1'($urandom_range(0, 1));
			else if (t < fsd)
				lvl = 1'b0;
			else if (t > last_sample)
				lvl = 1'b1;
			else
				lvl = value[(t - fsd + bt - 1) / bt];
			tk = random_requests(lvl, pop_pct, flush_pct, clr_pct);
			if (t == last_sample)
				tk = tk | on_store;
			queue_tick(tk);
		end
		frames_sent++;
	endtask

	// random line levels, then idle line long enough to finish any character begun
	task automatic send_noise(input int pop_pct);
		int pad;
		pad = eff_first_delay() + (char_bits() + stop_count()) * eff_bit_time() + 1;
		repeat ($urandom_range(1, 12))
			queue_tick(random_requests(1'($urandom_range(0, 1)), pop_pct, 1, 4));
		repeat (pad)
			queue_tick(random_requests(1'b1, pop_pct, 1, 4));
	endtask

	initial begin
		#200000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int start_count, bt, pop_pct;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// requests on an empty store at the reset settings
		queue_tick(IDLE_LINE | POP_REQ);
		queue_tick(IDLE_LINE | FLUSH_REQ);
		queue_tick(IDLE_LINE | CLEAR_REQ);
		queue_tick(IDLE_LINE | POP_REQ | FLUSH_REQ | CLEAR_REQ);
		drain();

		// too few data bits, odd stop code, zero delays; flush on the store tick
		set_config(4, 0, 0, 0);
		send_frame(8'hE0, 0, 0, 0, FLUSH_REQ);
		send_frame(8'h1F, 0, 0, 0, NO_REQ);
		repeat (3)
			queue_tick(IDLE_LINE | POP_REQ);
		drain();

		// fill the store past full, then clear and pop on store ticks
		no_stall = 1'b1;
		set_config(5, 1, 1, 1);
		repeat (64)
			send_frame(8'($urandom_range(0, 255)), 0, 0, 2, NO_REQ);
		send_frame(8'($urandom_range(0, 255)), 0, 0, 0, CLEAR_REQ);
		send_frame(8'($urandom_range(0, 255)), 0, 0, 0, POP_REQ);
		repeat (66)
			queue_tick(random_requests(1'b1, 100, 0, 5));
		drain();
		no_stall = 1'b0;

		set_config(15, 2, 3, 5);
		repeat (3)
			send_frame(8'($urandom_range(0, 255)), 40, 1, 4, NO_REQ);
		drain();
		set_config(0, 3, 2, 0);
		repeat (3)
			send_frame(8'($urandom_range(0, 255)), 40, 1, 4, NO_REQ);
		drain();

		start_count = ticks_queued;
		while (ticks_queued - start_count < 100) begin
			bt = $urandom_range(0, 6);
			pop_pct = $urandom_range(0, 3) * 30;
			set_config(($urandom_range(0, 3) != 0) ? $urandom_range(5, 8) : $urandom_range(0, 15),
				$urandom_range(0, 3), bt, $urandom_range(0, 2 * bt + 2));
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(0, 7) == 0)
					send_noise(pop_pct);
				send_frame(8'($urandom_range(0, 255)), pop_pct, 1, 4, NO_REQ);
				repeat ($urandom_range(0, 3))
					queue_tick(random_requests(1'b1, pop_pct, 1, 4));
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d ticks with %0d characters framed over %0d register settings",
			ticks_taken, frames_sent, settings_used);
		$display("covered %0d bytes popped and %0d results with overflow flagged",
			bytes_popped, overflow_results);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
